### hdl/ata_dma_pkg.sv
// types, codes and constants shared by the ata dma channel sequencer modules
// no dependencies
`default_nettype none

package ata_dma_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_IO,
        PH_SYNC,
        PH_FLUSH
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_CHECK,
        C_ADV,
        C_LOAD,
        C_START,
        C_IOCHK,
        C_SYNCDONE,
        C_DEVSEL,
        C_FLUSHCMD,
        C_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        EM_START,
        EM_BM_STOP,
        EM_REJECT,
        EM_DONE,
        EM_DEVSEL,
        EM_FLUSH_CMD
    } emit_sel_t;

    typedef struct packed {
        logic [3:0] tries;
        logic [7:0] tag;
        logic       sync;
        logic       rd;
        logic       dev;
    } info_t;

    typedef struct packed {
        logic       latch_in;
        logic       enqueue;
        logic       load_head;
        logic       pop;
        logic       wr_info;
        logic       emit;
        emit_sel_t  sel;
        logic [3:0] step;
        logic [2:0] status;
        logic       dev;
        logic       flush_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       rej;
        logic       count_zero;
        logic       lba48;
        logic       err;
        logic       retry;
        logic       sync_eff;
        logic       head_dev;
        logic       drv_busy;
        logic       dma_irq;
        logic       emit_ok;
        logic       flush_ok;
    } dp_status_t;

    localparam logic [1:0] FUNC_SUBMIT = 2'd0;
    localparam logic [1:0] FUNC_FLUSH  = 2'd1;

    localparam logic [1:0] KIND_TF   = 2'd0;
    localparam logic [1:0] KIND_BM   = 2'd1;
    localparam logic [1:0] KIND_DESC = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_IO_ERR = 3'd1;
    localparam logic [2:0] ST_NO_DEV = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    localparam logic [1:0] CFG_DEV0_BLOCKS = 2'd0;
    localparam logic [1:0] CFG_DEV1_BLOCKS = 2'd1;
    localparam logic [1:0] CFG_PRD_ADDR    = 2'd2;

    localparam logic [2:0] TF_SECCNT  = 3'd2;
    localparam logic [2:0] TF_LBA_LO  = 3'd3;
    localparam logic [2:0] TF_LBA_MID = 3'd4;
    localparam logic [2:0] TF_LBA_HI  = 3'd5;
    localparam logic [2:0] TF_DEVICE  = 3'd6;
    localparam logic [2:0] TF_COMMAND = 3'd7;
    localparam logic [2:0] BM_CMD     = 3'd0;
    localparam logic [2:0] BM_STATUS  = 3'd2;
    localparam logic [2:0] BM_PRD     = 3'd4;
    localparam logic [2:0] DESC_ADDR  = 3'd0;
    localparam logic [2:0] DESC_COUNT = 3'd1;

    localparam logic [7:0]  CMD_READ_DMA      = 8'hC8;
    localparam logic [7:0]  CMD_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0]  CMD_WRITE_DMA     = 8'hCA;
    localparam logic [7:0]  CMD_WRITE_DMA_EXT = 8'h35;
    localparam logic [7:0]  CMD_FLUSH_CACHE   = 8'hE7;
    localparam logic [31:0] PRD_EOT           = 32'h8000_0000;
    localparam logic [7:0]  DEVSEL_BASE       = 8'h40;
    localparam logic [7:0]  BM_START_READ     = 8'h09;
    localparam logic [7:0]  BM_START_WRITE    = 8'h01;
    localparam logic [7:0]  BM_STATUS_CLEAR   = 8'h06;

    // results kept per input, later ones are dropped
    localparam logic [4:0]  MAX_RESULTS       = 5'd17;

    localparam logic [3:0] STEP_DESC_ADDR  = 4'd0;
    localparam logic [3:0] STEP_DESC_COUNT = 4'd1;
    localparam logic [3:0] STEP_BM_PRD     = 4'd2;
    localparam logic [3:0] STEP_BM_STATUS  = 4'd3;
    localparam logic [3:0] STEP_TF_DEVICE  = 4'd4;
    localparam logic [3:0] STEP_SECCNT_HI  = 4'd5;
    localparam logic [3:0] STEP_LBA_LO_HI  = 4'd6;
    localparam logic [3:0] STEP_LBA_MID_HI = 4'd7;
    localparam logic [3:0] STEP_LBA_HI_HI  = 4'd8;
    localparam logic [3:0] STEP_SECCNT     = 4'd9;
    localparam logic [3:0] STEP_LBA_LO     = 4'd10;
    localparam logic [3:0] STEP_LBA_MID    = 4'd11;
    localparam logic [3:0] STEP_LBA_HI     = 4'd12;
    localparam logic [3:0] STEP_TF_COMMAND = 4'd13;
    localparam logic [3:0] STEP_BM_START   = 4'd14;

    function automatic logic [7:0] devsel(input logic dev);
        return DEVSEL_BASE | {3'b000, dev, 4'b0000};
    endfunction

endpackage

`default_nettype wire

### hdl/ata_dma_ctrl.sv
// controller state machine of the ata dma channel sequencer
// depends on ata_dma_pkg
`default_nettype none

module ata_dma_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire ata_dma_pkg::dp_status_t st,
    output ata_dma_pkg::dp_cmd_t        cmd
);

    ata_dma_pkg::ctrl_state_t state_reg, state_next;
    ata_dma_pkg::phase_t      phase_reg, phase_next;
    logic [1:0]               flush_pending_reg, flush_pending_next;
    logic                     dev_reg, dev_next;
    logic [3:0]               step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ata_dma_pkg::C_IDLE;
            phase_reg         <= ata_dma_pkg::PH_IDLE;
            flush_pending_reg <= 2'b00;
            dev_reg           <= 1'b0;
            step_reg          <= 4'd0;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            flush_pending_reg <= flush_pending_next;
            dev_reg           <= dev_next;
            step_reg          <= step_next;
        end
    end

    always_comb begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        flush_pending_next = flush_pending_reg;
        dev_next           = dev_reg;
        step_next          = step_reg;
        s_tready           = 1'b0;
        cmd                = '0;
        cmd.sel            = ata_dma_pkg::EM_START;
        cmd.step           = step_reg;
        cmd.dev            = dev_reg;
        case (state_reg)
            ata_dma_pkg::C_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ata_dma_pkg::C_CHECK;
                end
            end
            ata_dma_pkg::C_CHECK: begin
                if (st.func == ata_dma_pkg::FUNC_SUBMIT) begin
                    if (st.rej) begin
                        if (st.emit_ok) begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = ata_dma_pkg::EM_REJECT;
                            state_next = ata_dma_pkg::C_FINISH;
                        end
                    end else begin
                        cmd.enqueue = 1'b1;
                        state_next  = ata_dma_pkg::C_ADV;
                    end
                end else begin
                    if (st.func == ata_dma_pkg::FUNC_FLUSH) begin
                        flush_pending_next = 2'b11;
                    end
                    state_next = ata_dma_pkg::C_ADV;
                end
            end
            ata_dma_pkg::C_ADV: begin
                case (phase_reg)
                    ata_dma_pkg::PH_IDLE: begin
                        if (flush_pending_reg != 2'b00) begin
                            dev_next           = ~flush_pending_reg[0];
                            flush_pending_next = flush_pending_reg[0] ?
                                                 (flush_pending_reg & 2'b10) : 2'b00;
                            phase_next         = ata_dma_pkg::PH_FLUSH;
                            state_next         = ata_dma_pkg::C_DEVSEL;
                        end else if (!st.count_zero) begin
                            cmd.load_head = 1'b1;
                            state_next    = ata_dma_pkg::C_LOAD;
                        end else begin
                            state_next = ata_dma_pkg::C_FINISH;
                        end
                    end
                    ata_dma_pkg::PH_IO: begin
                        if (st.count_zero) begin
                            phase_next = ata_dma_pkg::PH_IDLE;
                        end else if (!st.dma_irq) begin
                            state_next = ata_dma_pkg::C_FINISH;
                        end else if (st.emit_ok) begin
                            cmd.emit      = 1'b1;
                            cmd.sel       = ata_dma_pkg::EM_BM_STOP;
                            cmd.load_head = 1'b1;
                            state_next    = ata_dma_pkg::C_IOCHK;
                        end
                    end
                    default: begin
                        if (st.drv_busy) begin
                            state_next = ata_dma_pkg::C_FINISH;
                        end else if (phase_reg == ata_dma_pkg::PH_SYNC && !st.count_zero) begin
                            cmd.load_head = 1'b1;
                            state_next    = ata_dma_pkg::C_SYNCDONE;
                        end else begin
                            phase_next = ata_dma_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
            ata_dma_pkg::C_LOAD: begin
                step_next  = ata_dma_pkg::STEP_DESC_ADDR;
                state_next = ata_dma_pkg::C_START;
            end
            ata_dma_pkg::C_START: begin
                if (st.emit_ok) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = ata_dma_pkg::EM_START;
                    if (step_reg == ata_dma_pkg::STEP_BM_START) begin
                        phase_next = ata_dma_pkg::PH_IO;
                        state_next = ata_dma_pkg::C_FINISH;
                    end else if (step_reg == ata_dma_pkg::STEP_TF_DEVICE && !st.lba48) begin
                        step_next = ata_dma_pkg::STEP_SECCNT;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            ata_dma_pkg::C_IOCHK: begin
                if (st.emit_ok) begin
                    cmd.wr_info = st.err;
                    if (st.retry) begin
                        phase_next = ata_dma_pkg::PH_IDLE;
                        state_next = ata_dma_pkg::C_ADV;
                    end else if (st.sync_eff) begin
                        dev_next   = st.head_dev;
                        phase_next = ata_dma_pkg::PH_SYNC;
                        state_next = ata_dma_pkg::C_DEVSEL;
                    end else begin
                        cmd.pop    = 1'b1;
                        cmd.emit   = 1'b1;
                        cmd.sel    = ata_dma_pkg::EM_DONE;
                        cmd.status = st.err ? ata_dma_pkg::ST_IO_ERR : ata_dma_pkg::ST_OK;
                        phase_next = ata_dma_pkg::PH_IDLE;
                        state_next = ata_dma_pkg::C_ADV;
                    end
                end
            end
            ata_dma_pkg::C_SYNCDONE: begin
                if (st.emit_ok) begin
                    cmd.pop    = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.sel    = ata_dma_pkg::EM_DONE;
                    cmd.status = ata_dma_pkg::ST_OK;
                    phase_next = ata_dma_pkg::PH_IDLE;
                    state_next = ata_dma_pkg::C_ADV;
                end
            end
            ata_dma_pkg::C_DEVSEL: begin
                if (st.emit_ok) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = ata_dma_pkg::EM_DEVSEL;
                    state_next = ata_dma_pkg::C_FLUSHCMD;
                end
            end
            ata_dma_pkg::C_FLUSHCMD: begin
                if (st.emit_ok) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = ata_dma_pkg::EM_FLUSH_CMD;
                    state_next = ata_dma_pkg::C_FINISH;
                end
            end
            ata_dma_pkg::C_FINISH: begin
                if (st.flush_ok) begin
                    cmd.flush_out = 1'b1;
                    state_next    = ata_dma_pkg::C_IDLE;
                end
            end
            default: begin
                state_next = ata_dma_pkg::C_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/ata_dma_dp.sv
// datapath of the ata dma channel sequencer: config, request queue,
// register write values and the output stage; depends on ata_dma_pkg
`default_nettype none

module ata_dma_dp #(
    parameter int QUEUE_DEPTH     = 8,
    parameter int SECTORS_PER_BLK = 8,
    parameter int TRY_LIMIT       = 3
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [44:0]            cfg_wdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic [103:0]           s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [47:0]                 m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    input  wire ata_dma_pkg::dp_cmd_t   cmd,
    output ata_dma_pkg::dp_status_t     st
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SEC_W = 53;
    localparam logic [7:0]  SPB8     = 8'(SECTORS_PER_BLK);
    localparam logic [15:0] XFER_LEN = 16'((SECTORS_PER_BLK * 512) % 65536);

    logic [44:0] dev0_blocks_reg, dev1_blocks_reg;
    logic [31:0] prd_addr_reg;

    logic [1:0]  func_reg;
    logic        in_dev_reg, in_read_reg, in_sync_reg;
    logic [44:0] in_block_reg;
    logic [31:0] in_buf_reg;
    logic [7:0]  in_tag_reg, drv_reg, dma_reg;

    logic [44:0] qblock_mem [QUEUE_DEPTH];
    logic [31:0] qbuf_mem   [QUEUE_DEPTH];
    ata_dma_pkg::info_t qinfo_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_idx;

    logic [44:0]        head_block_reg;
    logic [31:0]        head_buf_reg;
    ata_dma_pkg::info_t head_info_reg, info_wb;
    logic [SEC_W-1:0]   sector_reg;
    logic [47:0]        sec;
    logic [4:0]         tries_new;

    logic [44:0] dev_size;
    logic [2:0]  rej_code;

    logic [1:0]  e_kind;
    logic [2:0]  e_off;
    logic [31:0] e_val;
    logic [7:0]  e_tag;
    logic [2:0]  e_st;

    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pend_kind_reg;
    logic [45:0] pend_data_reg;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg;
    logic [45:0] m_data_reg;
    logic        m_last_reg;
    logic        out_free, move_out;
    logic [4:0]  res_cnt_reg;
    logic        emit_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev0_blocks_reg <= '0;
            dev1_blocks_reg <= '0;
            prd_addr_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ata_dma_pkg::CFG_DEV0_BLOCKS: dev0_blocks_reg <= cfg_wdata;
                ata_dma_pkg::CFG_DEV1_BLOCKS: dev1_blocks_reg <= cfg_wdata;
                ata_dma_pkg::CFG_PRD_ADDR:    prd_addr_reg    <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            func_reg     <= s_tuser;
            in_dev_reg   <= s_tdata[0];
            in_block_reg <= s_tdata[45:1];
            in_read_reg  <= s_tdata[46];
            in_sync_reg  <= s_tdata[47];
            in_buf_reg   <= s_tdata[79:48];
            in_tag_reg   <= s_tdata[87:80];
            drv_reg      <= s_tdata[95:88];
            dma_reg      <= s_tdata[103:96];
        end
    end

    // queue pointers
    always_comb begin
        tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        tail_idx   = tail_sum[IDX_W-1:0];
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.enqueue) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
            head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        tries_new     = {1'b0, head_info_reg.tries} + 5'd1;
        info_wb       = head_info_reg;
        info_wb.tries = tries_new[3:0];
        if (tries_new >= 5'(TRY_LIMIT)) begin
            info_wb.sync = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enqueue) begin
            qblock_mem[tail_idx] <= in_block_reg;
            qbuf_mem[tail_idx]   <= in_buf_reg;
            qinfo_mem[tail_idx]  <= '{tries: 4'd0, tag: in_tag_reg, sync: in_sync_reg,
                                      rd: in_read_reg, dev: in_dev_reg};
        end else if (cmd.wr_info) begin
            qinfo_mem[head_reg] <= info_wb;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_head) begin
            head_block_reg <= qblock_mem[head_reg];
            head_buf_reg   <= qbuf_mem[head_reg];
            head_info_reg  <= qinfo_mem[head_reg];
        end else if (cmd.wr_info) begin
            head_info_reg  <= info_wb;
        end
        sector_reg <= {8'd0, head_block_reg} * {45'd0, SPB8};
    end

    assign sec = sector_reg[47:0];

    always_comb begin
        dev_size = in_dev_reg ? dev1_blocks_reg : dev0_blocks_reg;
        if (dev_size == '0) begin
            rej_code = ata_dma_pkg::ST_NO_DEV;
        end else if (in_block_reg >= dev_size) begin
            rej_code = ata_dma_pkg::ST_RANGE;
        end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
            rej_code = ata_dma_pkg::ST_FULL;
        end else begin
            rej_code = ata_dma_pkg::ST_OK;
        end
    end

    // value of the next register write or completion
    always_comb begin
        e_kind = ata_dma_pkg::KIND_TF;
        e_off  = 3'd0;
        e_val  = 32'd0;
        e_tag  = 8'd0;
        e_st   = ata_dma_pkg::ST_OK;
        case (cmd.sel)
            ata_dma_pkg::EM_START: begin
                case (cmd.step)
                    ata_dma_pkg::STEP_DESC_ADDR: begin
                        e_kind = ata_dma_pkg::KIND_DESC;
                        e_off  = ata_dma_pkg::DESC_ADDR;
                        e_val  = head_buf_reg;
                    end
                    ata_dma_pkg::STEP_DESC_COUNT: begin
                        e_kind = ata_dma_pkg::KIND_DESC;
                        e_off  = ata_dma_pkg::DESC_COUNT;
                        e_val  = ata_dma_pkg::PRD_EOT | {16'd0, XFER_LEN};
                    end
                    ata_dma_pkg::STEP_BM_PRD: begin
                        e_kind = ata_dma_pkg::KIND_BM;
                        e_off  = ata_dma_pkg::BM_PRD;
                        e_val  = prd_addr_reg;
                    end
                    ata_dma_pkg::STEP_BM_STATUS: begin
                        e_kind = ata_dma_pkg::KIND_BM;
                        e_off  = ata_dma_pkg::BM_STATUS;
                        e_val  = {24'd0, ata_dma_pkg::BM_STATUS_CLEAR};
                    end
                    ata_dma_pkg::STEP_TF_DEVICE: begin
                        e_off = ata_dma_pkg::TF_DEVICE;
                        e_val = {24'd0, ata_dma_pkg::devsel(head_info_reg.dev)
                                 | (st.lba48 ? 8'd0 : {4'd0, sec[27:24]})};
                    end
                    ata_dma_pkg::STEP_SECCNT_HI: begin
                        e_off = ata_dma_pkg::TF_SECCNT;
                    end
                    ata_dma_pkg::STEP_LBA_LO_HI: begin
                        e_off = ata_dma_pkg::TF_LBA_LO;
                        e_val = {24'd0, sec[31:24]};
                    end
                    ata_dma_pkg::STEP_LBA_MID_HI: begin
                        e_off = ata_dma_pkg::TF_LBA_MID;
                        e_val = {24'd0, sec[39:32]};
                    end
                    ata_dma_pkg::STEP_LBA_HI_HI: begin
                        e_off = ata_dma_pkg::TF_LBA_HI;
                        e_val = {24'd0, sec[47:40]};
                    end
                    ata_dma_pkg::STEP_SECCNT: begin
                        e_off = ata_dma_pkg::TF_SECCNT;
                        e_val = {24'd0, SPB8};
                    end
                    ata_dma_pkg::STEP_LBA_LO: begin
                        e_off = ata_dma_pkg::TF_LBA_LO;
                        e_val = {24'd0, sec[7:0]};
                    end
                    ata_dma_pkg::STEP_LBA_MID: begin
                        e_off = ata_dma_pkg::TF_LBA_MID;
                        e_val = {24'd0, sec[15:8]};
                    end
                    ata_dma_pkg::STEP_LBA_HI: begin
                        e_off = ata_dma_pkg::TF_LBA_HI;
                        e_val = {24'd0, sec[23:16]};
                    end
                    ata_dma_pkg::STEP_TF_COMMAND: begin
                        e_off = ata_dma_pkg::TF_COMMAND;
                        if (head_info_reg.rd) begin
                            e_val = {24'd0, st.lba48 ? ata_dma_pkg::CMD_READ_DMA_EXT
                                                     : ata_dma_pkg::CMD_READ_DMA};
                        end else begin
                            e_val = {24'd0, st.lba48 ? ata_dma_pkg::CMD_WRITE_DMA_EXT
                                                     : ata_dma_pkg::CMD_WRITE_DMA};
                        end
                    end
                    ata_dma_pkg::STEP_BM_START: begin
                        e_kind = ata_dma_pkg::KIND_BM;
                        e_off  = ata_dma_pkg::BM_CMD;
                        e_val  = {24'd0, head_info_reg.rd ? ata_dma_pkg::BM_START_READ
                                                         : ata_dma_pkg::BM_START_WRITE};
                    end
                    default: ;
                endcase
            end
            ata_dma_pkg::EM_BM_STOP: begin
                e_kind = ata_dma_pkg::KIND_BM;
                e_off  = ata_dma_pkg::BM_CMD;
            end
            ata_dma_pkg::EM_REJECT: begin
                e_kind = ata_dma_pkg::KIND_DONE;
                e_tag  = in_tag_reg;
                e_st   = rej_code;
            end
            ata_dma_pkg::EM_DONE: begin
                e_kind = ata_dma_pkg::KIND_DONE;
                e_tag  = head_info_reg.tag;
                e_st   = cmd.status;
            end
            ata_dma_pkg::EM_DEVSEL: begin
                e_off = ata_dma_pkg::TF_DEVICE;
                e_val = {24'd0, ata_dma_pkg::devsel(cmd.dev)};
            end
            ata_dma_pkg::EM_FLUSH_CMD: begin
                e_off = ata_dma_pkg::TF_COMMAND;
                e_val = {24'd0, ata_dma_pkg::CMD_FLUSH_CACHE};
            end
            default: ;
        endcase
    end

    // results past the per-input limit are dropped
    assign emit_go = cmd.emit && (res_cnt_reg != ata_dma_pkg::MAX_RESULTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 5'd0;
        end else if (cmd.latch_in) begin
            res_cnt_reg <= 5'd0;
        end else if (emit_go) begin
            res_cnt_reg <= res_cnt_reg + 5'd1;
        end
    end

    // one held result so the final one can carry tlast
    assign out_free = !m_valid_reg || m_tready;
    assign move_out = pend_valid_reg && (emit_go || cmd.flush_out);

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (move_out) begin
            m_valid_next = 1'b1;
        end
        pend_valid_next = pend_valid_reg;
        if (emit_go) begin
            pend_valid_next = 1'b1;
        end else if (cmd.flush_out) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            pend_kind_reg <= e_kind;
            pend_data_reg <= {e_st, e_tag, e_val, e_off};
        end
        if (move_out) begin
            m_kind_reg <= pend_kind_reg;
            m_data_reg <= pend_data_reg;
            m_last_reg <= cmd.flush_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign st.func       = func_reg;
    assign st.rej        = (rej_code != ata_dma_pkg::ST_OK);
    assign st.count_zero = (count_reg == '0);
    assign st.lba48      = |sector_reg[SEC_W-1:28];
    assign st.err        = drv_reg[0] | dma_reg[1];
    assign st.retry      = (drv_reg[0] | dma_reg[1]) && (tries_new < 5'(TRY_LIMIT));
    assign st.sync_eff   = head_info_reg.sync && !(drv_reg[0] | dma_reg[1]);
    assign st.head_dev   = head_info_reg.dev;
    assign st.drv_busy   = drv_reg[7];
    assign st.dma_irq    = dma_reg[2];
    assign st.emit_ok    = !pend_valid_reg || out_free;
    assign st.flush_ok   = !pend_valid_reg || out_free;

endmodule

`default_nettype wire

### hdl/ata_dma_channel_sequencer.sv
// ata dma channel sequencer, top level: controller plus datapath
// when the input makes no result, s_tready returns after the check, advance and finish states;
// a completion or retry may be followed by an lba48 start, with results made one per cycle
// while the sequence runs and m_tready does not stall the output; one input at a time
// synchronous active-low reset clears the queue, phase, pending flushes and config
`default_nettype none

module ata_dma_channel_sequencer #(
    parameter int QUEUE_DEPTH     = 8,
    parameter int SECTORS_PER_BLK = 8,
    parameter int TRY_LIMIT       = 3
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [44:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // req_device, req_block, req_read, req_sync, buffer_addr, req_tag, drive_status,
    // dma_status
    input  wire logic [103:0] s_tdata,
    // func
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // reg_offset, write_value, done_tag, done_status, zero pad
    output logic [47:0]       m_tdata,
    // kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    ata_dma_pkg::dp_cmd_t    cmd;
    ata_dma_pkg::dp_status_t st;

    ata_dma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ata_dma_dp #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .SECTORS_PER_BLK (SECTORS_PER_BLK),
        .TRY_LIMIT       (TRY_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire
